[rtl/core/r2fft_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_pkg: shared types and constants
// Sequencer states, register indexes, widths and the quarter-sine table.
// ----------------------------------------------------------------------------
package r2fft_pkg;

    localparam int MAX_POINTS_DEF   = 64;
    localparam int TWIDDLE_BITS_DEF = 18;
    localparam int SAMPLE_W = 16;
    localparam int WORK_W   = 23;
    localparam int BIN_W    = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;
    localparam int ROM_BITS   = 24;

    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOG2_POINTS  = 1'd1;

    typedef enum logic [2:0] {
        ST_LOAD, ST_PAD, ST_BREV, ST_BFLY, ST_SCALE, ST_EMIT
    } t_state;

    // sin(2 pi m / 64), m = 0..16, Q1.23
    function automatic logic signed [ROM_BITS:0] quarter_sine(input logic [4:0] m);
        logic signed [ROM_BITS:0] v;
        case (m)
            5'd0:  v = 25'sd0;
            5'd1:  v = 25'sd822227;
            5'd2:  v = 25'sd1636536;
            5'd3:  v = 25'sd2435084;
            5'd4:  v = 25'sd3210181;
            5'd5:  v = 25'sd3954362;
            5'd6:  v = 25'sd4660461;
            5'd7:  v = 25'sd5321677;
            5'd8:  v = 25'sd5931642;
            5'd9:  v = 25'sd6484482;
            5'd10: v = 25'sd6974873;
            5'd11: v = 25'sd7398092;
            5'd12: v = 25'sd7750063;
            5'd13: v = 25'sd8027397;
            5'd14: v = 25'sd8227423;
            5'd15: v = 25'sd8348215;
            default: v = 25'sd8388608;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/r2fft_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_sample_if / r2fft_bin_if: valid/ready channels
// Input sample channel and output bin channel.
// ----------------------------------------------------------------------------
interface r2fft_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_real;
    logic signed [15:0] sample_imag;
    logic               frame_end;
    modport source (output valid, sample_real, sample_imag, frame_end, input ready);
    modport sink   (input valid, sample_real, sample_imag, frame_end, output ready);
endinterface

interface r2fft_bin_if;
    logic               valid;
    logic               ready;
    logic signed [22:0] bin_real;
    logic signed [22:0] bin_imag;
    logic        [5:0]  bin_number;
    logic               last_bin;
    modport source (output valid, bin_real, bin_imag, bin_number, last_bin, input ready);
    modport sink   (input valid, bin_real, bin_imag, bin_number, last_bin, output ready);
endinterface

[rtl/core/r2fft_twiddle.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_twiddle: twiddle lookup
// cos and sin of 2 pi m / 64 at TWIDDLE_BITS-1 fraction bits, registered.
// ----------------------------------------------------------------------------
module r2fft_twiddle #(
    parameter int TWIDDLE_BITS = r2fft_pkg::TWIDDLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic [4:0]                i_m,
    output logic signed [TWIDDLE_BITS:0] o_cos,
    output logic signed [TWIDDLE_BITS:0] o_sin
);
    import r2fft_pkg::*;

    localparam int SH = ROM_BITS - TWIDDLE_BITS;

    function automatic logic signed [TWIDDLE_BITS:0] entry(input logic [4:0] idx);
        logic signed [ROM_BITS:0]   q;
        logic signed [ROM_BITS+1:0] v;
        q = quarter_sine(idx);
        v = {q[ROM_BITS], q} + (ROM_BITS+2)'(1 <<< (SH-1));
        return (TWIDDLE_BITS+1)'(v >>> SH);
    endfunction

    logic signed [TWIDDLE_BITS:0] n_cos, n_sin;

    always_comb begin
        if (i_m <= 5'd16) begin
            n_cos = entry(5'd16 - i_m);
            n_sin = entry(i_m);
        end else begin
            n_cos = -entry(i_m - 5'd16);
            n_sin = entry(5'(6'd32 - {1'b0, i_m}));
        end
    end

    always_ff @(posedge i_clk) begin
        o_cos <= n_cos;
        o_sin <= n_sin;
    end
endmodule

[rtl/core/r2fft_bfly.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_bfly: shared butterfly unit
// Complex multiply of b by w, rounded, then saturated sum and difference.
// Two register stages: products, then outputs.
// ----------------------------------------------------------------------------
module r2fft_bfly #(
    parameter int TWIDDLE_BITS = r2fft_pkg::TWIDDLE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic signed [22:0]           i_ar,
    input  logic signed [22:0]           i_ai,
    input  logic signed [22:0]           i_br,
    input  logic signed [22:0]           i_bi,
    input  logic signed [TWIDDLE_BITS:0] i_wr,
    input  logic signed [TWIDDLE_BITS:0] i_wi,
    output logic signed [22:0]           o_pr,
    output logic signed [22:0]           o_pi,
    output logic signed [22:0]           o_qr,
    output logic signed [22:0]           o_qi
);
    localparam int PW = 23 + TWIDDLE_BITS + 1;
    localparam int FB = TWIDDLE_BITS - 1;

    logic signed [PW-1:0] r_m0, r_m1, r_m2, r_m3;
    logic signed [22:0]   r_ar, r_ai;

    always_ff @(posedge i_clk) begin
        r_m0 <= PW'(i_br) * PW'(i_wr);
        r_m1 <= PW'(i_bi) * PW'(i_wi);
        r_m2 <= PW'(i_br) * PW'(i_wi);
        r_m3 <= PW'(i_bi) * PW'(i_wr);
        r_ar <= i_ar;
        r_ai <= i_ai;
    end

    function automatic logic signed [22:0] sat(input logic signed [PW:0] v);
        if (v > (PW+1)'(4194303)) return 23'sd4194303;
        if (v < -(PW+1)'(4194304)) return -23'sd4194304;
        return 23'(v);
    endfunction

    logic signed [PW:0] vr, vi;

    always_comb begin
        vr = ((PW+1)'(r_m0) - (PW+1)'(r_m1) + (PW+1)'(1 <<< (FB-1))) >>> FB;
        vi = ((PW+1)'(r_m2) + (PW+1)'(r_m3) + (PW+1)'(1 <<< (FB-1))) >>> FB;
    end

    always_ff @(posedge i_clk) begin
        o_pr <= sat((PW+1)'(r_ar) + vr);
        o_pi <= sat((PW+1)'(r_ai) + vi);
        o_qr <= sat((PW+1)'(r_ar) - vr);
        o_qi <= sat((PW+1)'(r_ai) - vi);
    end
endmodule

[rtl/core/radix2_fft_frame.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix2_fft_frame: frame radix-2 DIT FFT
// Collects a frame, bit-reverses, runs butterflies on one shared unit and
// streams the bins out in natural order.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while the frame fills. After the last
// sample (or frame_end) the block holds ready low until the last bin leaves:
// zero padding fills the remaining addresses, bit reversal visits each index
// and swaps each pair with two reads and two writes, each of the L stages
// runs its butterflies through the one memory port (two reads and two writes
// each) and lets the butterfly pipe drain before the next stage, inverse
// scaling reads and writes every point, then each bin is read and held until
// the sink takes it. Throughput is set by the single-ported work memory
// feeding the shared butterfly unit.
module radix2_fft_frame #(
    parameter int MAX_POINTS   = r2fft_pkg::MAX_POINTS_DEF,
    parameter int TWIDDLE_BITS = r2fft_pkg::TWIDDLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [r2fft_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [r2fft_pkg::CFG_DATA_W-1:0] i_cfg_data,
    r2fft_sample_if.sink                     s_in,
    r2fft_bin_if.source                      m_out
);
    import r2fft_pkg::*;

    localparam int LIM = (MAX_POINTS >= 64) ? 6 : (MAX_POINTS >= 32) ? 5 :
                         (MAX_POINTS >= 16) ? 4 : (MAX_POINTS >= 8) ? 3 :
                         (MAX_POINTS >= 4) ? 2 : 1;

    logic       r_inv;
    logic [2:0] r_log2;
    t_state     r_state, n_state;
    logic [6:0] r_cnt, n_cnt;      // loaded count / address sweep
    logic [2:0] r_stage, n_stage;  // butterfly stage 1..L
    logic [5:0] r_bf, n_bf;        // butterfly index in stage
    logic [1:0] r_ph, n_ph;        // phase within butterfly or swap

    logic signed [22:0] mem_r [64];
    logic signed [22:0] mem_i [64];
    logic signed [22:0] r_rd_r, r_rd_i, r_ar, r_ai, r_br, r_bi;
    logic signed [22:0] r_tr, r_ti; // saved q results

    // butterfly write-back pipe
    logic       r_qpend;
    logic [5:0] r_qa, r_pa2;
    logic       r_bf_wr;
    logic [1:0] r_wpipe;
    logic [5:0] r_pa0, r_pa1, r_qa0, r_qa1;
    logic       bf_busy;
    assign bf_busy = (|r_wpipe) | r_bf_wr | r_qpend;

    // active length
    logic [2:0] lg;
    always_comb begin
        lg = r_log2;
        if (lg < 3'd1) lg = 3'd1;
        if (lg > 3'd6) lg = 3'd6;
        if (lg > 3'(LIM)) lg = 3'(LIM);
    end
    logic [6:0] npts;
    assign npts = 7'd1 << lg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv  <= 1'b0;
            r_log2 <= 3'd6;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_INVERSE_MODE: r_inv  <= i_cfg_data[0];
                REG_LOG2_POINTS:  r_log2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // bit reverse of r_cnt over lg bits
    function automatic logic [5:0] brev(input logic [5:0] v, input logic [2:0] l);
        logic [5:0] j;
        j = '0;
        for (int b = 0; b < 6; b++)
            if (b < l && v[b]) j = j | (6'd1 << (l - 3'd1 - 3'(b)));
        return j;
    endfunction

    // butterfly addressing
    logic [5:0] half, grp, kk, pa, qa;
    always_comb begin
        half = 6'd1 << (r_stage - 3'd1);
        kk   = r_bf & (half - 6'd1);
        grp  = (r_bf & ~(half - 6'd1)) << 1;
        pa   = grp | kk;
        qa   = pa | half;
    end
    logic [4:0] tw_m;
    assign tw_m = 5'(kk << (3'd6 - r_stage));

    logic signed [TWIDDLE_BITS:0] w_cos, w_sin, w_im;
    r2fft_twiddle #(.TWIDDLE_BITS(TWIDDLE_BITS)) u_tw (
        .i_clk(i_clk), .i_m(tw_m), .o_cos(w_cos), .o_sin(w_sin));
    assign w_im = r_inv ? w_sin : -w_sin;

    logic signed [22:0] bo_pr, bo_pi, bo_qr, bo_qi;
    r2fft_bfly #(.TWIDDLE_BITS(TWIDDLE_BITS)) u_bf (
        .i_clk(i_clk), .i_ar(r_ar), .i_ai(r_ai), .i_br(r_br), .i_bi(r_bi),
        .i_wr(w_cos), .i_wi(w_im),
        .o_pr(bo_pr), .o_pi(bo_pi), .o_qr(bo_qr), .o_qi(bo_qi));

    // single port memory control
    logic               we, rd_en;
    logic [5:0]         wa, ra;
    logic signed [22:0] wd_r, wd_i;
    logic               out_load, out_hold;

    // inverse scaling
    logic signed [23:0] sc_r, sc_i;
    assign sc_r = ($signed({r_rd_r[22], r_rd_r}) + (24'sd1 <<< (lg - 3'd1))) >>> lg;
    assign sc_i = ($signed({r_rd_i[22], r_rd_i}) + (24'sd1 <<< (lg - 3'd1))) >>> lg;

    logic [5:0] rv;
    assign rv = brev(r_cnt[5:0], lg);

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt; n_stage = r_stage; n_bf = r_bf; n_ph = r_ph;
        we = 1'b0; wa = '0; wd_r = '0; wd_i = '0;
        rd_en = 1'b0; ra = '0;
        s_in.ready = 1'b0;
        out_load = 1'b0;
        case (r_state)
            ST_LOAD: begin
                s_in.ready = 1'b1;
                if (s_in.valid) begin
                    if (r_cnt >= npts) begin
                        // overrun after length change: drop the request
                        n_state = ST_BREV; n_cnt = '0; n_ph = '0;
                    end else begin
                        we = 1'b1; wa = r_cnt[5:0];
                        wd_r = 23'(s_in.sample_real);
                        wd_i = 23'(s_in.sample_imag);
                        n_cnt = r_cnt + 7'd1;
                        if (n_cnt >= npts) begin
                            n_state = ST_BREV; n_cnt = '0; n_ph = '0;
                        end else if (s_in.frame_end) n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                we = 1'b1; wa = r_cnt[5:0];
                n_cnt = r_cnt + 7'd1;
                if (n_cnt >= npts) begin
                    n_state = ST_BREV; n_cnt = '0; n_ph = '0;
                end
            end
            ST_BREV: begin
                // swap i and rev(i) when i < rev(i): read i, read j, write, write
                if ({1'b0, r_cnt[5:0]} >= npts || r_cnt[6]) begin
                    n_state = ST_BFLY; n_stage = 3'd1; n_bf = '0; n_ph = '0;
                end else if (r_cnt[5:0] >= rv) begin
                    n_cnt = r_cnt + 7'd1;
                end else begin
                    case (r_ph)
                        2'd0: begin rd_en = 1'b1; ra = r_cnt[5:0]; n_ph = 2'd1; end
                        2'd1: begin rd_en = 1'b1; ra = rv; n_ph = 2'd2; end
                        2'd2: begin
                            we = 1'b1; wa = r_cnt[5:0]; wd_r = r_rd_r; wd_i = r_rd_i;
                            n_ph = 2'd3;
                        end
                        default: begin
                            we = 1'b1; wa = rv; wd_r = r_ar; wd_i = r_ai;
                            n_ph = 2'd0; n_cnt = r_cnt + 7'd1;
                        end
                    endcase
                end
            end
            ST_BFLY: begin
                // ph0 read q, ph1 read p, ph2 latch p, ph3 issue to the unit;
                // a new stage waits until the previous stage has landed
                case (r_ph)
                    2'd0: begin
                        if (!(r_bf == '0 && bf_busy)) begin
                            rd_en = 1'b1; ra = qa; n_ph = 2'd1;
                        end
                    end
                    2'd1: begin rd_en = 1'b1; ra = pa; n_ph = 2'd2; end
                    2'd2: n_ph = 2'd3;
                    default: begin
                        n_ph = 2'd0;
                        if ({1'b0, r_bf} + 7'd1 >= (npts >> 1)) begin
                            n_bf = '0;
                            if (r_stage >= lg) begin
                                n_stage = r_stage;
                                n_state = r_inv ? ST_SCALE : ST_EMIT;
                                n_cnt = '0; n_ph = '0;
                            end else n_stage = r_stage + 3'd1;
                        end else n_bf = r_bf + 6'd1;
                    end
                endcase
            end
            ST_SCALE: begin
                // ph0 read, ph1 write
                if (r_ph == 2'd0) begin
                    if (!bf_busy) begin
                        rd_en = 1'b1; ra = r_cnt[5:0]; n_ph = 2'd1;
                    end
                end else begin
                    we = 1'b1; wa = r_cnt[5:0];
                    wd_r = 23'(sc_r); wd_i = 23'(sc_i);
                    n_ph = 2'd0; n_cnt = r_cnt + 7'd1;
                    if (n_cnt >= npts) begin n_state = ST_EMIT; n_cnt = '0; end
                end
            end
            ST_EMIT: begin
                // ph0 read, ph1 load the output stage, ph2 present until taken
                if (r_ph == 2'd0) begin
                    if (!bf_busy) begin
                        rd_en = 1'b1; ra = r_cnt[5:0]; n_ph = 2'd1;
                    end
                end else if (r_ph == 2'd1) begin
                    out_load = 1'b1; n_ph = 2'd2;
                end else if (m_out.ready) begin
                    n_ph = 2'd0; n_cnt = r_cnt + 7'd1;
                    if (n_cnt >= npts) begin n_state = ST_LOAD; n_cnt = '0; end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_r <= mem_r[ra];
            r_rd_i <= mem_i[ra];
        end
        if (we) begin
            mem_r[wa] <= wd_r;
            mem_i[wa] <= wd_i;
        end else if (r_bf_wr) begin
            mem_r[r_pa2] <= bo_pr;
            mem_i[r_pa2] <= bo_pi;
        end else if (r_qpend) begin
            mem_r[r_qa] <= r_tr;
            mem_i[r_qa] <= r_ti;
        end
    end

    // operand capture for swap and butterfly
    always_ff @(posedge i_clk) begin
        if (r_state == ST_BREV && r_ph == 2'd1) begin
            r_ar <= r_rd_r; r_ai <= r_rd_i;
        end
        if (r_state == ST_BFLY && r_ph == 2'd1) begin
            r_br <= r_rd_r; r_bi <= r_rd_i;
        end
        if (r_state == ST_BFLY && r_ph == 2'd2) begin
            r_ar <= r_rd_r; r_ai <= r_rd_i;
        end
        if (r_bf_wr) begin
            r_tr <= bo_qr; r_ti <= bo_qi;
        end
    end

    // butterfly write-back timing: operands and twiddle are valid in ph3,
    // the unit registers products and then sums, so the results hold through
    // ph1 and ph2 of the next slot: write p in ph2, q in ph3. The next
    // slot reads other addresses of the same stage meanwhile.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt <= '0; r_stage <= 3'd1; r_bf <= '0; r_ph <= '0;
            r_wpipe <= '0; r_bf_wr <= 1'b0; r_qpend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt; r_stage <= n_stage; r_bf <= n_bf; r_ph <= n_ph;
            r_wpipe <= {r_wpipe[0], (r_state == ST_BFLY && r_ph == 2'd3)};
            r_bf_wr <= r_wpipe[1];
            r_qpend <= r_bf_wr;
        end
        r_pa0 <= pa; r_qa0 <= qa;
        if (r_wpipe[0]) begin r_pa1 <= r_pa0; r_qa1 <= r_qa0; end
        if (r_wpipe[1]) begin r_pa2 <= r_pa1; r_qa <= r_qa1; end
    end

    // output stage
    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (out_load) r_ov <= 1'b1;
        else if (m_out.ready) r_ov <= 1'b0;
        if (out_load) begin
            m_out.bin_real   <= r_rd_r;
            m_out.bin_imag   <= r_rd_i;
            m_out.bin_number <= r_cnt[5:0];
            m_out.last_bin   <= (r_cnt + 7'd1 == npts);
        end
    end
    assign out_hold = r_ov;
    assign m_out.valid = out_hold;
endmodule

[dv/radix2_fft_frame_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix2_fft_frame_tb: self-checking bench for the frame FFT
// Feeds sample frames through the request channel, predicts every bin with a
// fixed-point FFT model of its own and compares each bin as it leaves.
// ----------------------------------------------------------------------------
module radix2_fft_frame_tb;
    import r2fft_pkg::*;

    typedef struct packed {
        logic signed [WORK_W-1:0] re;
        logic signed [WORK_W-1:0] im;
        logic [BIN_W-1:0]         num;
        logic                     last;
    } t_bin;

    localparam longint SAT_HI = 4194303;
    localparam longint SAT_LO = -4194304;
    localparam longint SINE_Q23 [17] = '{0, 822227, 1636536, 2435084, 3210181,
        3954362, 4660461, 5321677, 5931642, 6484482, 6974873, 7398092, 7750063,
        8027397, 8227423, 8348215, 8388608};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    r2fft_sample_if s_if ();
    r2fft_bin_if    m_if ();

    radix2_fft_frame u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (s_if.sink),
        .m_out      (m_if.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    longint mem_re [64];
    longint mem_im [64];
    int     loaded;
    bit     inv_mode;
    int     log2_reg;
    t_bin   bins_pending [$];
    int     errors;
    bit     calm;
    int     sent;

    function automatic longint rnd_shift(longint v, int s);
        if (s == 0) return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip23(longint v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    function automatic longint sine_rom(int idx);
        return rnd_shift(SINE_Q23[idx], ROM_BITS - TWIDDLE_BITS_DEF);
    endfunction

    function automatic int eff_log2();
        if (log2_reg < 1) return 1;
        if (log2_reg > 6) return 6;
        return log2_reg;
    endfunction

    task automatic run_fft(int lg);
        int n, j, half, span, m;
        longint t, wr, ws, wi, br, bi, vr, vi, ur, ui;
        n = 1 << lg;
        for (int i = 0; i < n; i++) begin
            j = 0;
            for (int b = 0; b < lg; b++)
                if (i[b]) j |= 1 << (lg - 1 - b);
            if (i < j) begin
                t = mem_re[i]; mem_re[i] = mem_re[j]; mem_re[j] = t;
                t = mem_im[i]; mem_im[i] = mem_im[j]; mem_im[j] = t;
            end
        end
        for (int st = 1; st <= lg; st++) begin
            half = 1 << (st - 1);
            span = 1 << st;
            for (int g = 0; g < n; g += span) begin
                for (int k = 0; k < half; k++) begin
                    m = (k << (6 - st)) & 31;
                    if (m <= 16) begin
                        wr = sine_rom(16 - m);
                        ws = sine_rom(m);
                    end else begin
                        wr = -sine_rom(m - 16);
                        ws = sine_rom(32 - m);
                    end
                    wi = inv_mode ? ws : -ws;
                    br = mem_re[g+k+half]; bi = mem_im[g+k+half];
                    vr = rnd_shift(br * wr - bi * wi, TWIDDLE_BITS_DEF - 1);
                    vi = rnd_shift(br * wi + bi * wr, TWIDDLE_BITS_DEF - 1);
                    ur = mem_re[g+k]; ui = mem_im[g+k];
                    mem_re[g+k] = clip23(ur + vr);
                    mem_im[g+k] = clip23(ui + vi);
                    mem_re[g+k+half] = clip23(ur - vr);
                    mem_im[g+k+half] = clip23(ui - vi);
                end
            end
        end
        if (inv_mode) begin
            for (int i = 0; i < n; i++) begin
                mem_re[i] = clip23(rnd_shift(mem_re[i], lg));
                mem_im[i] = clip23(rnd_shift(mem_im[i], lg));
            end
        end
    endtask

    task automatic predict_bins(logic signed [15:0] re, logic signed [15:0] im, logic fend);
        int lg, n;
        t_bin b;
        lg = eff_log2();
        n = 1 << lg;
        if (loaded < n) begin
            mem_re[loaded] = re;
            mem_im[loaded] = im;
            loaded++;
            if (loaded < n && !fend) return;
            for (int i = loaded; i < n; i++) begin
                mem_re[i] = 0;
                mem_im[i] = 0;
            end
        end
        // a full frame after a length cut drops the sample and completes
        run_fft(lg);
        for (int i = 0; i < n; i++) begin
            b.re   = mem_re[i][WORK_W-1:0];
            b.im   = mem_im[i][WORK_W-1:0];
            b.num  = i[BIN_W-1:0];
            b.last = (i == n - 1);
            bins_pending = {bins_pending, b};
        end
        loaded = 0;
    endtask

    // output side: random stall, check each bin
    always @(posedge i_clk) begin
        t_bin got, want;
        m_if.ready <= calm || ($urandom_range(99) >= 13);
        if (i_rst_n && m_if.valid && m_if.ready) begin
            got = '{m_if.bin_real, m_if.bin_imag, m_if.bin_number, m_if.last_bin};
            if (bins_pending.size() == 0) begin
                $display("%0t: unexpected bin, got %h", $time, got);
                errors++;
            end else begin
                want = bins_pending.pop_front();
                if (got.re !== want.re)
                    $display("%0t: bin_real exp %0d got %0d", $time, want.re, got.re);
                if (got.im !== want.im)
                    $display("%0t: bin_imag exp %0d got %0d", $time, want.im, got.im);
                if (got.num !== want.num)
                    $display("%0t: bin_number exp %0d got %0d", $time, want.num, got.num);
                if (got.last !== want.last)
                    $display("%0t: last_bin exp %0d got %0d", $time, want.last, got.last);
                if (got !== want) errors++;
            end
        end
    end

    task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im, logic fend);
        int gap;
        gap = (!calm && $urandom_range(99) < 13) ? $urandom_range(4, 1) : 0;
        if (gap > 0) begin
            s_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_if.valid       <= 1'b1;
        s_if.sample_real <= re;
        s_if.sample_imag <= im;
        s_if.frame_end   <= fend;
        do @(posedge i_clk); while (!s_if.ready);
        predict_bins(re, im, fend);
        sent++;
    endtask

    task automatic wait_drained();
        s_if.valid <= 1'b0;
        while (bins_pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_INVERSE_MODE) inv_mode = val[0];
        else log2_reg = val[2:0];
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_frame(int cnt, bit mark_end);
        for (int i = 0; i < cnt; i++)
            send_sample(rand_word(), rand_word(), mark_end && i == cnt - 1);
    endtask

    task automatic test_extremes();
        write_reg(REG_INVERSE_MODE, 0);
        write_reg(REG_LOG2_POINTS, 1);
        send_sample(16'sh7fff, -16'sh8000, 1'b0);
        send_sample(-16'sh8000, 16'sh7fff, 1'b0);
        write_reg(REG_LOG2_POINTS, 2);
        send_sample(16'sh7fff, 16'sh7fff, 1'b1);     // padded frame
    endtask

    task automatic test_lengths();
        write_reg(REG_LOG2_POINTS, 0);               // acts as two points
        send_sample(16'sh1234, -16'sh0001, 1'b1);
        write_reg(REG_LOG2_POINTS, 7);               // acts as 64 points
        send_sample(-16'sh8000, -16'sh8000, 1'b0);
        send_sample(16'sh7fff, 16'sh0000, 1'b0);
        send_sample(16'sh0001, 16'sh7fff, 1'b1);
    endtask

    task automatic test_inverse();
        write_reg(REG_INVERSE_MODE, 1);
        write_reg(REG_LOG2_POINTS, 3);
        send_frame(8, 0);
        write_reg(REG_LOG2_POINTS, 1);
        send_sample(-16'sh8000, -16'sh8000, 1'b1);
        write_reg(REG_INVERSE_MODE, 0);
    endtask

    task automatic test_overrun();
        // hold a partial long frame, then cut the length below it
        write_reg(REG_LOG2_POINTS, 6);
        send_frame(5, 0);
        write_reg(REG_LOG2_POINTS, 2);
        send_sample(16'sh5555, 16'shaaaa, 1'b0);     // dropped
    endtask

    task automatic test_random();
        int lg, n, cnt;
        while (sent < 110) begin
            if ($urandom_range(2) == 0) write_reg(REG_INVERSE_MODE, $urandom_range(1));
            if ($urandom_range(1) == 0) begin
                lg = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(4, 1);
                write_reg(REG_LOG2_POINTS, lg);
            end
            calm = (sent >= 60 && sent < 85);
            n = 1 << eff_log2();
            if ($urandom_range(9) == 0) begin
                for (int i = 0; i < 3; i++)
                    send_sample(rand_word(), rand_word(), $urandom_range(3) == 0);
            end else begin
                cnt = $urandom_range(n, 1);
                if (cnt > 110 - sent) cnt = 110 - sent;
                send_frame(cnt, cnt < n || $urandom_range(1));
            end
            if (sent > 95 && sent < 100) wait_drained();
        end
        calm = 1'b0;
    endtask

    initial begin
        s_if.valid       = 1'b0;
        s_if.sample_real = '0;
        s_if.sample_imag = '0;
        s_if.frame_end   = 1'b0;
        m_if.ready       = 1'b0;
        errors   = 0;
        sent     = 0;
        calm     = 1'b0;
        loaded   = 0;
        inv_mode = 1'b0;
        log2_reg = 6;
        for (int i = 0; i < 64; i++) begin
            mem_re[i] = 0;
            mem_im[i] = 0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_lengths();
        test_inverse();
        test_overrun();
        test_random();
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (errors == 0 && bins_pending.size() == 0)
            $display("radix2_fft_frame verification clean");
        else
            $display("radix2_fft_frame verification failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("radix2_fft_frame verification failed");
        $finish;
    end

endmodule

[radix2_fft_frame.f]
rtl/core/r2fft_pkg.sv
rtl/core/r2fft_stream_if.sv
rtl/core/r2fft_twiddle.sv
rtl/core/r2fft_bfly.sv
rtl/core/radix2_fft_frame.sv
dv/radix2_fft_frame_tb.sv
